[rtl/core/oble_pkg.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// oble_pkg
// Shared widths, limits, codes and types of the order book level engine.
// ---------------------------------------------------------------------------
package oble_pkg;

  localparam int QTY_W       = 48;
  localparam int VOL_W       = 56;
  localparam int RATE_W      = 17;
  localparam int SUM_W       = 64;
  localparam int OUT_PRICE_W = 32;
  localparam int CFG_W       = 20;
  localparam int CFG_IDX_W   = 2;
  localparam int IN_DATA_W   = 80;
  localparam int IN_USER_W   = 4;
  localparam int OUT_DATA_W  = 480;
  localparam int OUT_USER_W  = 2;

  localparam logic [VOL_W-1:0]  VOL_MAX  = {VOL_W{1'b1}};
  localparam logic [QTY_W-1:0]  QTY_MAX  = {QTY_W{1'b1}};
  localparam logic [RATE_W-1:0] RATE_ONE = 17'h10000;

  localparam logic [CFG_IDX_W-1:0] REG_MA_LENGTH   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FILTER_EN   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FILTER_PCT  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ERASE_THR   = 2'd3;

  typedef enum logic [1:0] {
    STAT_OK   = 2'd0,
    STAT_FULL = 2'd1,
    STAT_CMP  = 2'd2
  } status_t;

  typedef enum logic [9:0] {
    ST_IDLE     = 10'b0000000001,
    ST_UPD_SCAN = 10'b0000000010,
    ST_UPD_WR   = 10'b0000000100,
    ST_BEST     = 10'b0000001000,
    ST_BAND     = 10'b0000010000,
    ST_SUM      = 10'b0000100000,
    ST_RATE     = 10'b0001000000,
    ST_HIST     = 10'b0010000000,
    ST_DIV      = 10'b0100000000,
    ST_PUSH     = 10'b1000000000
  } state_t;

endpackage

[rtl/core/oble_div.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// oble_div
// Restoring divider, one quotient bit per cycle, for the history averages.
// ---------------------------------------------------------------------------
module oble_div #(
  parameter int DIV_W = 5
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [oble_pkg::SUM_W-1:0] dividend,
  input  logic [DIV_W-1:0]          divisor,
  output logic                      busy,
  output logic [oble_pkg::SUM_W-1:0] quotient
);
  import oble_pkg::*;

  localparam int CNT_W = $clog2(SUM_W + 1);

  logic [CNT_W-1:0] cnt;
  logic [DIV_W-1:0] rem;
  logic [DIV_W:0]   rem_sh;
  logic [DIV_W:0]   rem_diff;
  logic             q_bit;
  logic [DIV_W-1:0] rem_next;

  always_comb begin
    rem_sh   = {rem, quotient[SUM_W-1]};
    rem_diff = rem_sh - {1'b0, divisor};
    q_bit    = (rem_sh >= {1'b0, divisor});
    rem_next = q_bit ? rem_diff[DIV_W-1:0] : rem_sh[DIV_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CNT_W'(SUM_W);
    end else if (busy) begin
      if (cnt == CNT_W'(1)) begin
        busy <= 1'b0;
      end
      cnt <= cnt - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quotient <= dividend;
      rem      <= '0;
    end else if (busy) begin
      quotient <= {quotient[SUM_W-2:0], q_bit};
      rem      <= rem_next;
    end
  end

endmodule

[rtl/core/order_book_level_engine.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// order_book_level_engine
// Bid and ask price-level tables with spread, balance and moving averages.
// ---------------------------------------------------------------------------
// one request at a time; the result register frees the input side
// update: one table read per cycle for the key search
// compute: paced by the two table walks, the history walk, the 17-step
//   ratio loop and the bit-serial averages
// reset clears valid bits, history count and head, extremes and registers;
//   table and history memories are not cleared
module order_book_level_engine #(
  parameter int BOOK_DEPTH    = 64,
  parameter int HISTORY_DEPTH = 16,
  parameter int PRICE_BITS    = 32
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // price, quantity
  input  logic [oble_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  // action, side, snapshot_entry, snapshot_start
  input  logic [oble_pkg::IN_USER_W-1:0]  s_axis_tuser,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // best_ask, best_bid, ask_volume, bid_volume, bid_rate, avg_bid_rate,
  // avg_ask_volume, avg_bid_volume, avg_total_volume, highest_quantity,
  // lowest_quantity, zero pad
  output logic [oble_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  // status
  output logic [oble_pkg::OUT_USER_W-1:0] m_axis_tuser,
  input  logic                            cfg_we,
  input  logic [oble_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [oble_pkg::CFG_W-1:0]      cfg_data
);
  import oble_pkg::*;

  localparam int IDX_W   = (BOOK_DEPTH > 1) ? $clog2(BOOK_DEPTH) : 1;
  localparam int CNT_W   = $clog2(BOOK_DEPTH + 1);
  localparam int HIDX_W  = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int HCNT_W  = $clog2(HISTORY_DEPTH + 1);
  localparam int ENT_W   = PRICE_BITS + QTY_W;
  localparam int BAND_W  = PRICE_BITS + 8;
  localparam int HENT_W  = RATE_W + 3 * VOL_W;
  localparam logic [PRICE_BITS-1:0] PRICE_MASK = {PRICE_BITS{1'b1}};

  // configuration
  logic [4:0]        ma_length;
  logic              filter_enable;
  logic [6:0]        filter_range_pct;
  logic [CFG_W-1:0]  erase_threshold;

  always_ff @(posedge clk) begin
    if (rst) begin
      ma_length        <= 5'd8;
      filter_enable    <= 1'b0;
      filter_range_pct <= 7'd0;
      erase_threshold  <= CFG_W'(10);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MA_LENGTH:  ma_length        <= cfg_data[4:0];
        REG_FILTER_EN:  filter_enable    <= cfg_data[0];
        REG_FILTER_PCT: filter_range_pct <= cfg_data[6:0];
        REG_ERASE_THR:  erase_threshold  <= cfg_data;
        default:        ma_length        <= ma_length;
      endcase
    end
  end

  logic [HCNT_W-1:0] len_cur;
  always_comb begin
    if (ma_length == 5'd0) begin
      len_cur = HCNT_W'(1);
    end else if (32'(ma_length) > HISTORY_DEPTH) begin
      len_cur = HCNT_W'(HISTORY_DEPTH);
    end else begin
      len_cur = HCNT_W'(ma_length);
    end
  end

  // state
  state_t state;
  logic [BOOK_DEPTH-1:0] bid_valid;
  logic [BOOK_DEPTH-1:0] ask_valid;
  logic [ENT_W-1:0] bid_mem [BOOK_DEPTH];
  logic [ENT_W-1:0] ask_mem [BOOK_DEPTH];
  logic [HENT_W-1:0] hist_mem [HISTORY_DEPTH];
  logic [ENT_W-1:0] bid_rd, ask_rd;
  logic [HENT_W-1:0] hist_rd;
  logic [HCNT_W-1:0] hist_count;
  logic [HIDX_W-1:0] hist_head;
  logic [QTY_W-1:0]  max_qty, min_qty;

  // latched request
  logic                  it_side, it_entry;
  logic [PRICE_BITS-1:0] it_price;
  logic [QTY_W-1:0]      it_qty;
  logic [63:0]           in_price64;
  assign in_price64 = 64'(s_axis_tdata[31:0]);

  // table walk
  logic [CNT_W-1:0] scnt;
  logic             p_vld;
  logic [IDX_W-1:0] p_idx;
  logic [IDX_W-1:0] rd_addr;
  logic             scan_state, scan_issue, scan_done;
  assign rd_addr    = scnt[IDX_W-1:0];
  assign scan_state = (state == ST_UPD_SCAN) || (state == ST_BEST) || (state == ST_SUM);
  assign scan_issue = scan_state && (scnt < CNT_W'(BOOK_DEPTH));
  assign scan_done  = (scnt == CNT_W'(BOOK_DEPTH)) && !p_vld;

  logic [PRICE_BITS-1:0] bid_p, ask_p, upd_p;
  logic [QTY_W-1:0]      bid_q, ask_q;
  logic                  upd_v;
  assign bid_p = bid_rd[PRICE_BITS-1:0];
  assign ask_p = ask_rd[PRICE_BITS-1:0];
  assign bid_q = bid_rd[ENT_W-1:PRICE_BITS];
  assign ask_q = ask_rd[ENT_W-1:PRICE_BITS];
  assign upd_p = it_side ? ask_p : bid_p;
  assign upd_v = it_side ? ask_valid[p_idx] : bid_valid[p_idx];

  // update search results
  logic             hit_f, free_f;
  logic [IDX_W-1:0] hit_idx, free_idx;

  // compute working registers
  logic [PRICE_BITS-1:0] best_ask, best_bid;
  logic [BAND_W-1:0]     ask_band, bid_band;
  logic [VOL_W-1:0]      av, bv, tv;
  logic [7:0]            ask_mul;
  logic [6:0]            bid_mul;
  logic [BAND_W-1:0]     ask_p100, bid_p100;
  logic                  ask_keep, bid_keep;
  logic [VOL_W:0]        av_sum, bv_sum, tv_sum;
  logic [VOL_W-1:0]      av_next, bv_next, tv_next;

  assign ask_mul  = 8'd100 + 8'(filter_range_pct);
  assign bid_mul  = (filter_range_pct > 7'd100) ? 7'd0 : 7'd100 - filter_range_pct;
  assign ask_p100 = BAND_W'(ask_p) * BAND_W'(100);
  assign bid_p100 = BAND_W'(bid_p) * BAND_W'(100);
  assign ask_keep = ask_valid[p_idx] && !(filter_enable && (ask_p100 > ask_band));
  assign bid_keep = bid_valid[p_idx] && !(filter_enable && (bid_p100 < bid_band));
  assign av_sum   = {1'b0, av} + (VOL_W + 1)'(ask_q);
  assign bv_sum   = {1'b0, bv} + (VOL_W + 1)'(bid_q);
  assign tv_sum   = {1'b0, av} + {1'b0, bv};
  assign av_next  = av_sum[VOL_W] ? VOL_MAX : av_sum[VOL_W-1:0];
  assign bv_next  = bv_sum[VOL_W] ? VOL_MAX : bv_sum[VOL_W-1:0];
  assign tv_next  = tv_sum[VOL_W] ? VOL_MAX : tv_sum[VOL_W-1:0];

  // extremes tracking
  logic [QTY_W-1:0] trk_max, trk_min;
  always_comb begin
    trk_max = max_qty;
    trk_min = min_qty;
    if (state == ST_UPD_WR) begin
      if (it_qty > trk_max) trk_max = it_qty;
      if (it_qty < trk_min) trk_min = it_qty;
    end else begin
      if (ask_keep) begin
        if (ask_q > trk_max) trk_max = ask_q;
        if (ask_q < trk_min) trk_min = ask_q;
      end
      if (bid_keep) begin
        if (bid_q > trk_max) trk_max = bid_q;
        if (bid_q < trk_min) trk_min = bid_q;
      end
    end
  end

  // bid share ratio, one quotient bit per step
  logic [4:0]        rk;
  logic [VOL_W:0]    rr;
  logic [RATE_W-1:0] rq;
  logic [VOL_W:0]    rr_sh, rr_next;
  logic [RATE_W-1:0] rq_sh, rq_next;
  logic [RATE_W-1:0] rate;
  always_comb begin
    rr_sh   = (rk == 5'd0) ? rr : {rr[VOL_W-1:0], 1'b0};
    rq_sh   = (rk == 5'd0) ? rq : {rq[RATE_W-2:0], 1'b0};
    rr_next = rr_sh;
    rq_next = rq_sh;
    if (rr_sh >= {1'b0, tv}) begin
      rr_next = rr_sh - {1'b0, tv};
      rq_next = rq_sh | RATE_W'(1);
    end
  end
  assign rate = (tv == '0) ? '0 : rq;

  // history walk
  logic [HCNT_W-1:0] hcnt;
  logic [HIDX_W-1:0] haddr;
  logic              hp_vld, h_issue, h_done;
  logic [SUM_W-1:0]  s_rate, s_av, s_bv, s_tv;
  assign h_issue = (state == ST_HIST) && (hcnt < hist_count);
  assign h_done  = (hcnt == hist_count) && !hp_vld;

  logic             div_start, div_busy;
  logic             busy_av, busy_bv, busy_tv;
  logic [SUM_W-1:0] q_rate, q_av, q_bv, q_tv;
  assign div_start = (state == ST_HIST) && h_done;

  oble_div #(.DIV_W(HCNT_W)) u_div_rate (
    .clk(clk), .rst(rst), .start(div_start), .dividend(s_rate),
    .divisor(len_cur), .busy(div_busy), .quotient(q_rate));
  oble_div #(.DIV_W(HCNT_W)) u_div_av (
    .clk(clk), .rst(rst), .start(div_start), .dividend(s_av),
    .divisor(len_cur), .busy(busy_av), .quotient(q_av));
  oble_div #(.DIV_W(HCNT_W)) u_div_bv (
    .clk(clk), .rst(rst), .start(div_start), .dividend(s_bv),
    .divisor(len_cur), .busy(busy_bv), .quotient(q_bv));
  oble_div #(.DIV_W(HCNT_W)) u_div_tv (
    .clk(clk), .rst(rst), .start(div_start), .dividend(s_tv),
    .divisor(len_cur), .busy(busy_tv), .quotient(q_tv));

  logic [RATE_W-1:0] avg_rate;
  logic [VOL_W-1:0]  avg_av, avg_bv, avg_tv;
  assign avg_rate = (q_rate > SUM_W'(RATE_ONE)) ? RATE_ONE : q_rate[RATE_W-1:0];
  assign avg_av   = (q_av > SUM_W'(VOL_MAX)) ? VOL_MAX : q_av[VOL_W-1:0];
  assign avg_bv   = (q_bv > SUM_W'(VOL_MAX)) ? VOL_MAX : q_bv[VOL_W-1:0];
  assign avg_tv   = ((q_tv > SUM_W'(VOL_MAX)) || busy_av || busy_bv || busy_tv) ?
                    VOL_MAX : q_tv[VOL_W-1:0];

  // table write control
  logic             out_free, upd_erase, res_load;
  logic             tbl_we;
  logic [IDX_W-1:0] tbl_waddr;
  logic [ENT_W-1:0] tbl_wdata;
  assign out_free  = !m_axis_tvalid || m_axis_tready;
  assign res_load  = out_free && ((state == ST_UPD_WR) || (state == ST_PUSH));
  assign upd_erase = !it_entry && (it_qty <= QTY_W'(erase_threshold));
  assign tbl_we    = (state == ST_UPD_WR) && out_free && !upd_erase && (hit_f || free_f);
  assign tbl_waddr = hit_f ? hit_idx : free_idx;
  assign tbl_wdata = {it_qty, it_price};

  logic [HIDX_W-1:0] head_dec;
  assign head_dec = (hist_head == '0) ? HIDX_W'(HISTORY_DEPTH - 1) : hist_head - HIDX_W'(1);

  logic [63:0] ba64, bb64;
  assign ba64 = 64'(best_ask);
  assign bb64 = 64'(best_bid);

  // memories
  always_ff @(posedge clk) begin
    bid_rd <= bid_mem[rd_addr];
    ask_rd <= ask_mem[rd_addr];
    if (tbl_we && !it_side) bid_mem[tbl_waddr] <= tbl_wdata;
    if (tbl_we && it_side)  ask_mem[tbl_waddr] <= tbl_wdata;
  end

  always_ff @(posedge clk) begin
    hist_rd <= hist_mem[haddr];
    if ((state == ST_PUSH) && out_free) begin
      hist_mem[hist_head] <= {tv, bv, av, rate};
    end
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      bid_valid     <= '0;
      ask_valid     <= '0;
      hist_count    <= '0;
      hist_head     <= '0;
      max_qty       <= '0;
      min_qty       <= QTY_MAX;
      m_axis_tvalid <= 1'b0;
      p_vld         <= 1'b0;
      hp_vld        <= 1'b0;
      scnt          <= '0;
      hcnt          <= '0;
    end else begin
      if (res_load) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tvalid && m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      p_vld  <= scan_issue;
      p_idx  <= rd_addr;
      hp_vld <= h_issue;
      if (scan_issue) scnt <= scnt + CNT_W'(1);
      if (h_issue) begin
        hcnt  <= hcnt + HCNT_W'(1);
        haddr <= (haddr == '0) ? HIDX_W'(HISTORY_DEPTH - 1) : haddr - HIDX_W'(1);
      end
      if (hp_vld) begin
        s_rate <= s_rate + SUM_W'(hist_rd[RATE_W-1:0]);
        s_av   <= s_av + SUM_W'(hist_rd[RATE_W+VOL_W-1:RATE_W]);
        s_bv   <= s_bv + SUM_W'(hist_rd[RATE_W+2*VOL_W-1:RATE_W+VOL_W]);
        s_tv   <= s_tv + SUM_W'(hist_rd[HENT_W-1:RATE_W+2*VOL_W]);
      end

      unique case (state)
        ST_IDLE: begin
          if (s_axis_tvalid) begin
            it_side  <= s_axis_tuser[1];
            it_entry <= s_axis_tuser[2];
            it_price <= in_price64[PRICE_BITS-1:0];
            it_qty   <= s_axis_tdata[79:32];
            scnt     <= '0;
            hit_f    <= 1'b0;
            free_f   <= 1'b0;
            best_ask <= PRICE_MASK;
            best_bid <= '0;
            if (s_axis_tuser[0]) begin
              state <= ST_BEST;
            end else begin
              if (s_axis_tuser[3]) begin
                max_qty <= '0;
                min_qty <= QTY_MAX;
              end
              state <= ST_UPD_SCAN;
            end
          end
        end
        ST_UPD_SCAN: begin
          if (p_vld) begin
            if (upd_v && (upd_p == it_price) && !hit_f) begin
              hit_f   <= 1'b1;
              hit_idx <= p_idx;
            end
            if (!upd_v && !free_f) begin
              free_f   <= 1'b1;
              free_idx <= p_idx;
            end
          end
          if (scan_done) state <= ST_UPD_WR;
        end
        ST_UPD_WR: begin
          if (out_free) begin
            if (upd_erase && hit_f && !it_side) bid_valid[hit_idx] <= 1'b0;
            if (upd_erase && hit_f && it_side)  ask_valid[hit_idx] <= 1'b0;
            if (!upd_erase && !hit_f && free_f && !it_side) bid_valid[free_idx] <= 1'b1;
            if (!upd_erase && !hit_f && free_f && it_side)  ask_valid[free_idx] <= 1'b1;
            max_qty       <= trk_max;
            min_qty       <= trk_min;
            m_axis_tuser  <= (!upd_erase && !hit_f && !free_f) ? STAT_FULL : STAT_OK;
            m_axis_tdata  <= {6'b0, trk_min, trk_max, 378'b0};
            state         <= ST_IDLE;
          end
        end
        ST_BEST: begin
          if (p_vld) begin
            if (ask_valid[p_idx] && (ask_p < best_ask)) best_ask <= ask_p;
            if (bid_valid[p_idx] && (bid_p > best_bid)) best_bid <= bid_p;
          end
          if (scan_done) state <= ST_BAND;
        end
        ST_BAND: begin
          ask_band <= BAND_W'(best_ask) * BAND_W'(ask_mul);
          bid_band <= BAND_W'(best_bid) * BAND_W'(bid_mul);
          if (filter_enable) begin
            max_qty <= '0;
            min_qty <= QTY_MAX;
          end
          av    <= '0;
          bv    <= '0;
          scnt  <= '0;
          state <= ST_SUM;
        end
        ST_SUM: begin
          if (p_vld) begin
            if (ask_valid[p_idx] && !ask_keep) ask_valid[p_idx] <= 1'b0;
            if (bid_valid[p_idx] && !bid_keep) bid_valid[p_idx] <= 1'b0;
            if (ask_keep) av <= av_next;
            if (bid_keep) bv <= bv_next;
            if (filter_enable) begin
              max_qty <= trk_max;
              min_qty <= trk_min;
            end
          end
          if (scan_done) begin
            tv    <= tv_next;
            rr    <= {1'b0, bv};
            rq    <= '0;
            rk    <= '0;
            state <= ST_RATE;
          end
        end
        ST_RATE: begin
          rr <= rr_next;
          rq <= rq_next;
          rk <= rk + 5'd1;
          if (rk == 5'd16) begin
            hcnt   <= '0;
            haddr  <= head_dec;
            s_rate <= '0;
            s_av   <= '0;
            s_bv   <= '0;
            s_tv   <= '0;
            state  <= ST_HIST;
          end
        end
        ST_HIST: begin
          if (h_done) state <= ST_DIV;
        end
        ST_DIV: begin
          if (!div_busy) state <= ST_PUSH;
        end
        ST_PUSH: begin
          if (out_free) begin
            hist_head <= (32'(hist_head) == HISTORY_DEPTH - 1) ? '0 : hist_head + HIDX_W'(1);
            hist_count <= ((hist_count + HCNT_W'(1)) < len_cur) ?
                          hist_count + HCNT_W'(1) : len_cur;
            m_axis_tuser  <= STAT_CMP;
            m_axis_tdata  <= {6'b0, min_qty, max_qty, avg_tv, avg_bv, avg_av, avg_rate,
                              rate, bv, av, bb64[31:0], ba64[31:0]};
            state         <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign s_axis_tready = (state == ST_IDLE);

  a_one_request: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("second request taken while one is in work");

  a_hist_bound: assert property (@(posedge clk) disable iff (rst)
    hist_count <= HCNT_W'(HISTORY_DEPTH))
    else $error("history count beyond depth");

  a_result_src: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> ($past(state) == ST_UPD_WR || $past(state) == ST_PUSH))
    else $error("result raised outside a finishing state");

endmodule

[test/tb_top.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top
// Checks the order book level engine against a cycle-free predictor of its
// bid/ask level tables, band filter, volume sums, Q16 balance and moving
// averages, under random idling on both streams and a long output hold-off.
// ---------------------------------------------------------------------------
module tb_top;
  import oble_pkg::*;

  localparam int LEVELS     = 64;
  localparam int HIST_SLOTS = 16;
  localparam int MAX_CYCLES = 3000000;

  typedef struct {
    bit          action;
    bit          side;
    bit          snap_entry;
    bit          snap_start;
    logic [31:0] price;
    logic [47:0] qty;
  } level_req_t;

  typedef struct {
    status_t                 status;
    logic [OUT_DATA_W-1:0]   data;
  } book_result_t;

  logic clk = 0;
  logic rst = 1;
  logic s_axis_tvalid = 0;
  logic s_axis_tready;
  logic [IN_DATA_W-1:0] s_axis_tdata = '0;
  logic [IN_USER_W-1:0] s_axis_tuser = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic [OUT_USER_W-1:0] m_axis_tuser;
  logic cfg_we = 0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;

  order_book_level_engine dut (.*);

  // predictor state
  logic [31:0] bid_px[LEVELS], ask_px[LEVELS];
  logic [47:0] bid_qty[LEVELS], ask_qty[LEVELS];
  bit          bid_live[LEVELS], ask_live[LEVELS];
  logic [63:0] h_rate[HIST_SLOTS], h_ask[HIST_SLOTS], h_bid[HIST_SLOTS], h_tot[HIST_SLOTS];
  int          h_count, h_head;
  logic [47:0] qty_hi, qty_lo;
  logic [4:0]  ma_len;
  logic        filt_en;
  logic [6:0]  filt_pct;
  logic [19:0] erase_thr;

  level_req_t   pending_reqs[$];
  book_result_t expected_results[$];
  int  cycle = 0;
  int  errors = 0;
  bit  in_taken = 0;
  int  hold_cycles = 0;
  bit  hold_done = 0;

  localparam int FLD_LSB[12] = '{0, 32, 64, 120, 176, 193, 210, 266, 322, 378, 426, 0};
  localparam int FLD_W[12]   = '{32, 32, 56, 56, 17, 17, 56, 56, 56, 48, 48, 0};

  initial forever #5 clk = ~clk;

  function automatic void track_qty(logic [47:0] q);
    if (q > qty_hi) qty_hi = q;
    if (q < qty_lo) qty_lo = q;
  endfunction

  function automatic logic [63:0] vol_add(logic [63:0] a, logic [63:0] b);
    logic [63:0] s;
    s = a + b;
    return (s > VOL_MAX) ? 64'(VOL_MAX) : s;
  endfunction

  function automatic logic [63:0] hist_mean(ref logic [63:0] h[HIST_SLOTS], input int len,
                                            input logic [63:0] cap);
    logic [63:0] sum;
    logic [63:0] avg;
    sum = 0;
    for (int k = 0; k < h_count; k++) sum += h[(h_head + HIST_SLOTS - 1 - k) % HIST_SLOTS];
    avg = sum / len;
    return (avg > cap) ? cap : avg;
  endfunction

  function automatic book_result_t predict_book(level_req_t r);
    book_result_t res;
    int hit, free_slot, len;
    logic [63:0] best_ask, best_bid, av, bv, tv, rate, pct, ask_band, bid_band;
    logic [127:0] num;
    res.status = STAT_OK;
    res.data = '0;
    if (!r.action) begin
      if (r.snap_start) begin
        qty_hi = '0;
        qty_lo = QTY_MAX;
      end
      hit = -1;
      free_slot = -1;
      for (int i = 0; i < LEVELS; i++) begin
        if (r.side) begin
          if (ask_live[i] && ask_px[i] == r.price && hit < 0) hit = i;
          if (!ask_live[i] && free_slot < 0) free_slot = i;
        end else begin
          if (bid_live[i] && bid_px[i] == r.price && hit < 0) hit = i;
          if (!bid_live[i] && free_slot < 0) free_slot = i;
        end
      end
      if (!r.snap_entry && r.qty <= 48'(erase_thr)) begin
        if (hit >= 0) begin
          if (r.side) ask_live[hit] = 0;
          else bid_live[hit] = 0;
        end
      end else if (hit >= 0) begin
        if (r.side) ask_qty[hit] = r.qty;
        else bid_qty[hit] = r.qty;
      end else if (free_slot >= 0) begin
        if (r.side) begin
          ask_px[free_slot] = r.price;
          ask_qty[free_slot] = r.qty;
          ask_live[free_slot] = 1;
        end else begin
          bid_px[free_slot] = r.price;
          bid_qty[free_slot] = r.qty;
          bid_live[free_slot] = 1;
        end
      end else begin
        res.status = STAT_FULL;
      end
      track_qty(r.qty);
    end else begin
      best_ask = 64'hFFFF_FFFF;
      best_bid = 0;
      for (int i = 0; i < LEVELS; i++) begin
        if (ask_live[i] && ask_px[i] < best_ask) best_ask = ask_px[i];
        if (bid_live[i] && bid_px[i] > best_bid) best_bid = bid_px[i];
      end
      if (filt_en) begin
        pct = filt_pct;
        ask_band = best_ask * (100 + pct);
        bid_band = best_bid * (100 - ((pct > 100) ? 100 : pct));
        for (int i = 0; i < LEVELS; i++) begin
          if (ask_live[i] && 64'(ask_px[i]) * 100 > ask_band) ask_live[i] = 0;
          if (bid_live[i] && 64'(bid_px[i]) * 100 < bid_band) bid_live[i] = 0;
        end
        qty_hi = '0;
        qty_lo = QTY_MAX;
        for (int i = 0; i < LEVELS; i++) begin
          if (ask_live[i]) track_qty(ask_qty[i]);
          if (bid_live[i]) track_qty(bid_qty[i]);
        end
      end
      av = 0;
      bv = 0;
      for (int i = 0; i < LEVELS; i++) begin
        if (ask_live[i]) av = vol_add(av, ask_qty[i]);
        if (bid_live[i]) bv = vol_add(bv, bid_qty[i]);
      end
      tv = vol_add(av, bv);
      rate = 0;
      if (tv != 0) begin
        num = {64'd0, bv} << 16;
        rate = 64'(num / tv);
      end
      len = (ma_len == 0) ? 1 : ((ma_len > HIST_SLOTS) ? HIST_SLOTS : int'(ma_len));
      res.status = STAT_CMP;
      res.data[31:0]    = best_ask[31:0];
      res.data[63:32]   = best_bid[31:0];
      res.data[119:64]  = av[55:0];
      res.data[175:120] = bv[55:0];
      res.data[192:176] = rate[16:0];
      res.data[209:193] = 17'(hist_mean(h_rate, len, 64'(RATE_ONE)));
      res.data[265:210] = 56'(hist_mean(h_ask, len, 64'(VOL_MAX)));
      res.data[321:266] = 56'(hist_mean(h_bid, len, 64'(VOL_MAX)));
      res.data[377:322] = 56'(hist_mean(h_tot, len, 64'(VOL_MAX)));
      h_rate[h_head] = rate;
      h_ask[h_head] = av;
      h_bid[h_head] = bv;
      h_tot[h_head] = tv;
      h_head = (h_head + 1) % HIST_SLOTS;
      h_count = (h_count + 1 < len) ? h_count + 1 : len;
    end
    res.data[425:378] = qty_hi;
    res.data[473:426] = qty_lo;
    return res;
  endfunction

  // driver
  always @(negedge clk) begin
    level_req_t r;
    bit quiet;
    quiet = (cycle > 20000 && cycle < 70000);
    if (!rst && (!s_axis_tvalid || in_taken)) begin
      if (pending_reqs.size() > 0 && (quiet || $urandom_range(0, 99) >= 9)) begin
        r = pending_reqs.pop_front();
        s_axis_tvalid <= 1;
        s_axis_tdata <= {r.qty, r.price};
        s_axis_tuser <= {r.snap_start, r.snap_entry, r.side, r.action};
      end else begin
        s_axis_tvalid <= 0;
      end
    end
  end

  // receiver with one long hold-off
  always @(negedge clk) begin
    if (!hold_done && cycle > 8000) begin
      hold_done <= 1;
      hold_cycles <= 3000;
      m_axis_tready <= 0;
    end else if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      m_axis_tready <= 0;
    end else begin
      m_axis_tready <= (cycle > 20000 && cycle < 70000) || ($urandom_range(0, 99) >= 9);
    end
  end

  // monitor
  always @(posedge clk) begin
    level_req_t r;
    book_result_t e;
    cycle <= cycle + 1;
    in_taken <= s_axis_tvalid && s_axis_tready;
    if (cycle > MAX_CYCLES) begin
      $display("[FAIL] regression broken");
      $finish;
    end
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_results.size() == 0) begin
          errors++;
          $display("%0t unexpected result status=%0d data=%h", $time, m_axis_tuser, m_axis_tdata);
        end else begin
          e = expected_results.pop_front();
          if (m_axis_tuser !== e.status) begin
            errors++;
            $display("%0t status exp=%0d got=%0d", $time, e.status, m_axis_tuser);
          end
          for (int f = 0; f < 11; f++) begin
            if (((m_axis_tdata ^ e.data) >> FLD_LSB[f]) & ((480'd1 << FLD_W[f]) - 1)) begin
              errors++;
              $display("%0t field %0d exp=%h got=%h", $time, f,
                       (e.data >> FLD_LSB[f]) & ((480'd1 << FLD_W[f]) - 1),
                       (m_axis_tdata >> FLD_LSB[f]) & ((480'd1 << FLD_W[f]) - 1));
            end
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        r.action = s_axis_tuser[0];
        r.side = s_axis_tuser[1];
        r.snap_entry = s_axis_tuser[2];
        r.snap_start = s_axis_tuser[3];
        r.price = s_axis_tdata[31:0];
        r.qty = s_axis_tdata[79:32];
        e = predict_book(r);
        expected_results = {expected_results, e};
      end
    end
  end

  task automatic wait_idle();
    while (pending_reqs.size() > 0 || s_axis_tvalid || expected_results.size() > 0)
      @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    @(negedge clk);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      REG_MA_LENGTH:  ma_len = val[4:0];
      REG_FILTER_EN:  filt_en = val[0];
      REG_FILTER_PCT: filt_pct = val[6:0];
      REG_ERASE_THR:  erase_thr = val[19:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 0;
  endtask

  task automatic add_req(bit act, bit sd, logic [31:0] px, logic [47:0] q, bit se, bit ss);
    level_req_t r;
    r.action = act;
    r.side = sd;
    r.price = px;
    r.qty = q;
    r.snap_entry = se;
    r.snap_start = ss;
    pending_reqs = {pending_reqs, r};
  endtask

  task automatic add_random(int n);
    bit sd;
    logic [31:0] px;
    logic [47:0] q;
    for (int i = 0; i < n; i++) begin
      sd = 1'($urandom_range(0, 1));
      if ($urandom_range(0, 99) < 5) px = $urandom();
      else px = sd ? 32'(1000 + $urandom_range(0, 90)) : 32'(910 + $urandom_range(0, 90));
      case ($urandom_range(0, 3))
        0: q = 48'($urandom_range(0, 20));
        1: q = 48'({$urandom(), $urandom()});
        default: q = 48'($urandom_range(0, 1000000));
      endcase
      if ($urandom_range(0, 99) < 14)
        add_req(1, sd, px, q, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      else
        add_req(0, sd, px, q, 1'($urandom_range(0, 1)), $urandom_range(0, 99) < 5);
    end
  endtask

  initial begin
    foreach (bid_live[i]) begin
      bid_live[i] = 0;
      ask_live[i] = 0;
    end
    h_count = 0;
    h_head = 0;
    qty_hi = '0;
    qty_lo = QTY_MAX;
    ma_len = 8;
    filt_en = 0;
    filt_pct = 0;
    erase_thr = 10;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 0;

    // directed: empty book, extremes, erase paths, band
    add_req(1, 0, 0, 0, 0, 0);
    add_req(0, 0, 0, 0, 0, 0);
    add_req(0, 1, 32'hFFFF_FFFF, QTY_MAX, 1, 0);
    add_req(0, 0, 32'hFFFF_FFFF, 48'd11, 0, 0);
    add_req(0, 0, 32'd0, 48'd1, 1, 0);
    add_req(1, 0, 0, 0, 0, 0);
    add_req(0, 0, 32'd0, 48'd10, 0, 0);
    add_req(0, 1, 32'd500, 48'd12345, 0, 1);
    add_req(0, 1, 32'd500, 48'd5000, 0, 0);
    add_req(0, 1, 32'd777, 48'd3, 0, 0);
    add_req(0, 0, 32'd480, 48'd700, 1, 0);
    add_req(0, 0, 32'd300, 48'd900, 1, 0);
    add_req(1, 1, 0, 0, 0, 0);
    add_req(0, 1, 32'hFFFF_FFFF, 48'd0, 0, 1);
    add_req(1, 0, 0, 0, 0, 0);
    wait_idle();
    write_reg(REG_FILTER_EN, 1);
    write_reg(REG_FILTER_PCT, 10);
    write_reg(REG_MA_LENGTH, 1);
    add_req(1, 0, 0, 0, 0, 0);
    add_req(1, 0, 0, 0, 0, 0);
    add_random(200);
    wait_idle();

    for (int ph = 0; ph < 7; ph++) begin
      case (ph)
        0: begin write_reg(REG_MA_LENGTH, 16); write_reg(REG_FILTER_EN, 0);
                 write_reg(REG_ERASE_THR, 0); end
        1: begin write_reg(REG_MA_LENGTH, 0); write_reg(REG_FILTER_EN, 1);
                 write_reg(REG_FILTER_PCT, 100); write_reg(REG_ERASE_THR, 1000000); end
        2: begin write_reg(REG_MA_LENGTH, 31); write_reg(REG_FILTER_PCT, 127);
                 write_reg(REG_ERASE_THR, 20'hFFFFF); end
        3: begin write_reg(REG_MA_LENGTH, 5); write_reg(REG_FILTER_PCT, 0);
                 write_reg(REG_ERASE_THR, 15); end
        4: begin write_reg(REG_MA_LENGTH, 12); write_reg(REG_FILTER_EN, 0);
                 write_reg(REG_ERASE_THR, 10); end
        default: begin
          write_reg(REG_MA_LENGTH, CFG_W'($urandom_range(1, 16)));
          write_reg(REG_FILTER_EN, CFG_W'($urandom_range(0, 1)));
          write_reg(REG_FILTER_PCT, CFG_W'($urandom_range(0, 20)));
          write_reg(REG_ERASE_THR, CFG_W'($urandom_range(0, 20)));
        end
      endcase
      add_random(200);
      wait_idle();
    end

    if (errors == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

endmodule
